[rtl/xor_frame_checker_dedup_top_macros.svh]
// Assertion macros used by the frame checker's port-level checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef XOR_FRAME_CHECKER_DEDUP_TOP_MACROS_SVH
`define XOR_FRAME_CHECKER_DEDUP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define XFCD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xfcd check failed");

// Next-cycle implication, disabled during reset
`define XFCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xfcd check failed");

`endif

[rtl/xfcd_pkg.sv]
// Types and constants of the XOR frame checker with duplicate-ID filter.
// No dependencies.
package xfcd_pkg;

	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned POS_W     = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_FIRST  = 8'd0,
		REG_HEADER_SECOND = 8'd1
	} cfg_reg_e;

	typedef enum logic [2:0] {
		ST_NEW          = 3'd0,
		ST_DUPLICATE    = 3'd1,
		ST_BAD_HEADER   = 3'd2,
		ST_BAD_CHECKSUM = 3'd3,
		ST_TOO_SHORT    = 3'd4
	} status_e;

	// Byte positions of the fixed frame fields
	localparam logic [POS_W-1:0] POS_HDR0    = 9'd0;
	localparam logic [POS_W-1:0] POS_HDR1    = 9'd1;
	localparam logic [POS_W-1:0] POS_CMD_HI  = 9'd2;
	localparam logic [POS_W-1:0] POS_CMD_LO  = 9'd3;
	localparam logic [POS_W-1:0] POS_LENGTH  = 9'd4;
	localparam logic [POS_W-1:0] POS_BODY    = 9'd5;
	localparam logic [POS_W-1:0] POS_MAX     = 9'h1FF;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
	} hdr_cfg_t;

	typedef struct packed {
		logic        report;
		status_e     status;
		logic [15:0] command;
		logic [7:0]  length;
	} verdict_t;

endpackage

[rtl/xfcd_ifs.sv]
// Channel interfaces of the frame checker: byte input, result output, config writes.
// Depends on xfcd_pkg.
interface xfcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, frame_byte, frame_last, input ready);
	modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

interface xfcd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] command;
	logic [7:0]  length_field;

	modport source (output valid, status, command, length_field, input ready);
	modport sink   (input valid, status, command, length_field, output ready);
endinterface

interface xfcd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [xfcd_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/xfcd_cfg_regs.sv]
// Configuration registers: expected header bytes.
// Depends on xfcd_pkg and xfcd_cfg_if.
module xfcd_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	xfcd_cfg_if.sink           cfg,
	output xfcd_pkg::hdr_cfg_t hdr
);

	xfcd_pkg::hdr_cfg_t hdr_q;

	assign cfg.ready = 1'b1;
	assign hdr       = hdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				xfcd_pkg::REG_HEADER_FIRST:  hdr_q.first  <= cfg.data;
				xfcd_pkg::REG_HEADER_SECOND: hdr_q.second <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/xfcd_frame_state.sv]
// Per-frame running state: header check, command/length capture, running XOR,
// ID shift register and the stored last ID. Depends on xfcd_pkg.
module xfcd_frame_state #(
	parameter int unsigned ID_BYTES = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         frame_byte,
	input  logic               frame_last,
	input  xfcd_pkg::hdr_cfg_t hdr,
	output xfcd_pkg::verdict_t verdict
);

	localparam int unsigned IdW = 8 * ID_BYTES;

	logic [xfcd_pkg::POS_W-1:0] pos_q;
	logic [7:0]                 xor_q;
	logic                       hdr_good_q;
	logic [7:0]                 len_q;
	logic [15:0]                cmd_q;
	logic                       csum_good_q;
	logic [IdW-1:0]             id_q;
	logic [IdW-1:0]             last_id_q;

	logic [xfcd_pkg::POS_W-1:0] pos_d;
	logic [7:0]                 xor_d;
	logic                       hdr_good_d;
	logic [7:0]                 len_d;
	logic [15:0]                cmd_d;
	logic                       csum_good_d;
	logic [IdW-1:0]             id_d;
	logic [9:0]                 pos_w;
	logic [9:0]                 len_w;
	logic                       in_xor;
	logic                       at_csum;
	logic                       in_id;
	xfcd_pkg::status_e          status;

	assign pos_w = {1'b0, pos_q};
	assign len_w = {2'b00, len_d};

	always_comb begin
		hdr_good_d = hdr_good_q;
		cmd_d      = cmd_q;
		len_d      = len_q;
		unique case (pos_q)
			xfcd_pkg::POS_HDR0:   hdr_good_d = hdr_good_q && (frame_byte == hdr.first);
			xfcd_pkg::POS_HDR1:   hdr_good_d = hdr_good_q && (frame_byte == hdr.second);
			xfcd_pkg::POS_CMD_HI: cmd_d      = {frame_byte, cmd_q[7:0]};
			xfcd_pkg::POS_CMD_LO: cmd_d      = {cmd_q[15:8], frame_byte};
			xfcd_pkg::POS_LENGTH: len_d      = frame_byte;
			default: ;
		endcase
	end

	// XOR covers bytes 2..4+L, checksum sits at 5+L, ID ends at 4+L
	always_comb begin
		in_xor  = (pos_q >= xfcd_pkg::POS_CMD_HI) &&
		          (pos_w <= len_w + 10'(xfcd_pkg::POS_LENGTH));
		at_csum = (pos_q >= xfcd_pkg::POS_BODY) &&
		          (pos_w == len_w + 10'(xfcd_pkg::POS_BODY));
		in_id   = (pos_q >= xfcd_pkg::POS_BODY) &&
		          (pos_w + 10'(ID_BYTES) >= len_w + 10'(xfcd_pkg::POS_BODY)) &&
		          (pos_w <= len_w + 10'(xfcd_pkg::POS_LENGTH));
	end

	always_comb begin
		xor_d       = in_xor ? (xor_q ^ frame_byte) : xor_q;
		csum_good_d = at_csum ? (frame_byte == xor_q) : csum_good_q;
		if (in_id) begin
			id_d = IdW'({id_q, frame_byte});
		end else begin
			id_d = id_q;
		end
		pos_d = (pos_q == xfcd_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
	end

	always_comb begin
		priority if (!hdr_good_d) begin
			status = xfcd_pkg::ST_BAD_HEADER;
		end else if (len_d < 8'(ID_BYTES)) begin
			status = xfcd_pkg::ST_TOO_SHORT;
		end else if (!csum_good_d) begin
			status = xfcd_pkg::ST_BAD_CHECKSUM;
		end else if (id_d == last_id_q) begin
			status = xfcd_pkg::ST_DUPLICATE;
		end else begin
			status = xfcd_pkg::ST_NEW;
		end
	end

	assign verdict.report  = step && frame_last;
	assign verdict.status  = status;
	assign verdict.command = cmd_d;
	assign verdict.length  = len_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			xor_q       <= '0;
			hdr_good_q  <= 1'b1;
			len_q       <= '0;
			cmd_q       <= '0;
			csum_good_q <= 1'b0;
			id_q        <= '0;
			last_id_q   <= '0;
		end else if (step) begin
			if (frame_last) begin
				// frame done: store a new ID, clear for the next frame
				if (status == xfcd_pkg::ST_NEW) begin
					last_id_q <= id_d;
				end
				pos_q       <= '0;
				xor_q       <= '0;
				hdr_good_q  <= 1'b1;
				len_q       <= '0;
				cmd_q       <= '0;
				csum_good_q <= 1'b0;
				id_q        <= '0;
			end else begin
				pos_q       <= pos_d;
				xor_q       <= xor_d;
				hdr_good_q  <= hdr_good_d;
				len_q       <= len_d;
				cmd_q       <= cmd_d;
				csum_good_q <= csum_good_d;
				id_q        <= id_d;
			end
		end
	end

endmodule

[rtl/xor_frame_checker_dedup_top.sv]
// XOR frame checker with duplicate-ID filter, top level.
// A result becomes valid once its last byte has passed the input register and been loaded
// into the result register; the byte may wait in the input register in between.
// Throughput: one byte per cycle; a last byte waits in the input register only while an
// earlier result is still stalled.
// Reset (arst_n low, asynchronous): headers, stored ID and frame state clear, no result pending.
module xor_frame_checker_dedup_top #(
	parameter int unsigned ID_BYTES = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	xfcd_byte_if.sink      frame_in,
	xfcd_result_if.source  result_out,
	xfcd_cfg_if.sink       cfg
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               advance;
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [15:0]        command_q;
	logic [7:0]         length_q;
	xfcd_pkg::hdr_cfg_t hdr;
	xfcd_pkg::verdict_t verdict;

	xfcd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.hdr    (hdr)
	);

	xfcd_frame_state #(
		.ID_BYTES (ID_BYTES)
	) u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.frame_byte (byte_s1),
		.frame_last (last_s1),
		.hdr        (hdr),
		.verdict    (verdict)
	);

	// Hold a last byte while the result register is full and not drained
	assign advance        = valid_s1 && (!last_s1 || !out_valid_q || result_out.ready);
	assign frame_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.ready && frame_in.valid) begin
			byte_s1 <= frame_in.frame_byte;
			last_s1 <= frame_in.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (verdict.report) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (verdict.report) begin
			status_q  <= verdict.status;
			command_q <= verdict.command;
			length_q  <= verdict.length;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.status       = status_q;
	assign result_out.command      = command_q;
	assign result_out.length_field = length_q;

endmodule

[rtl/xfcd_checker.sv]
// Port-level checks for the frame checker top level, bound to it below.
// Depends on xfcd_pkg and xor_frame_checker_dedup_top_macros.svh.
`include "xor_frame_checker_dedup_top_macros.svh"

module xfcd_checker #(
	parameter int unsigned ID_BYTES = 6
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_status,
	input logic [7:0] out_length
);

	logic in_last_xact;
	logic out_good;

	assign in_last_xact = in_valid && in_ready && in_last;
	assign out_good     = (out_status == xfcd_pkg::ST_NEW) ||
	                      (out_status == xfcd_pkg::ST_DUPLICATE);

	// a draining output never blocks the input
	`XFCD_ASSERT_IMPL(a_ready_follows, out_ready, in_ready)
	// a fresh result follows a last-byte transaction, through the input and result registers
	`XFCD_ASSERT_IMPL(a_result_latency, $rose(out_valid), $past(in_last_xact, 2))
	// an ID verdict needs a body long enough to hold the ID
	`XFCD_ASSERT_IMPL(a_id_needs_length, out_valid && out_good, out_length >= 8'(ID_BYTES))
	// hold a stalled result
	`XFCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))

endmodule

bind xor_frame_checker_dedup_top xfcd_checker #(
	.ID_BYTES (ID_BYTES)
) u_xfcd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (frame_in.valid),
	.in_ready   (frame_in.ready),
	.in_last    (frame_in.frame_last),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.out_status (result_out.status),
	.out_length (result_out.length_field)
);
